/* sv/two_level_local_branch_predictor_assert.svh */
`ifndef TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_ASSERT_SVH
`define TWO_LEVEL_LOCAL_BRANCH_PREDICTOR_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define BP2L_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bp2l check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define BP2L_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bp2l check failed");

`endif

/* sv/bp2l_pkg.sv */
package bp2l_pkg;

  // History table geometry: pc bits below HIST_AW pick the history register.
  localparam int HIST_ENTRIES  = 512;
  localparam int HIST_AW       = $clog2(HIST_ENTRIES);
  // Pattern table select: the next PAT_AW pc bits.
  localparam int PAT_TABLES    = 8;
  localparam int PAT_AW        = $clog2(PAT_TABLES);
  localparam int HIST_BITS_DEF = 6;

  typedef logic [1:0] ctr_t;

  localparam ctr_t CTR_RESET = 2'd1;  // weakly not taken

  localparam logic OP_PREDICT = 1'b0;
  localparam logic OP_UPDATE  = 1'b1;

  function automatic ctr_t next_counter(input ctr_t c, input logic correct);
    ctr_t n;
    n = c;
    if (correct) begin
      case (c)
        2'd1:    n = 2'd0;
        2'd2:    n = 2'd3;
        default: n = c;
      endcase
    end else begin
      case (c)
        2'd0:    n = 2'd1;
        2'd1:    n = 2'd2;
        2'd2:    n = 2'd1;
        default: n = 2'd2;
      endcase
    end
    return n;
  endfunction

  function automatic logic ctr_taken(input ctr_t c);
    return c[1];
  endfunction

endpackage

/* sv/bp2l_ram.sv */
module bp2l_ram #(
  parameter int AW = 9,
  parameter int DW = 6
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem_r [2**AW];
  logic [DW-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

/* sv/two_level_local_branch_predictor.sv */
// Two-level local branch predictor.
// Input channel (in_valid / in_stall): one access per item. in_operation selects
// a predict request or an update carrying the resolved and earlier predicted
// directions. Only pc[HIST_AW+PAT_AW-1:0] is used (bits 11:0 by default).
// Result channel (out_valid / out_stall): one item, out_prediction, for each
// predict request; updates return nothing.
// An item goes through three steps: accept and history read, counter read, then
// the result load or the counter and history write-back. Both tables sit in
// single-port-read synchronous RAMs, and the history read must land before the
// counter address is known, so the counter read waits for it. One item is in
// flight at a time, so no forwarding is needed.
// out_valid rises as a predict completes its last step, after the history and
// counter reads.
// After reset a clearing pass writes every entry of both tables, and in_stall
// stays high meanwhile.
// The result sits in an output register; while out_stall holds it, the next
// item is still accepted and worked on, and a second predict result waits in
// its last cycle until the register frees.
`include "two_level_local_branch_predictor_assert.svh"

module two_level_local_branch_predictor #(
  parameter int HISTORY_BITS = bp2l_pkg::HIST_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_operation,
  input  logic [31:0] in_pc,
  input  logic        in_resolved_taken,
  input  logic        in_predicted_taken,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_prediction
);

  localparam int HAW    = bp2l_pkg::HIST_AW;
  localparam int PAW    = bp2l_pkg::PAT_AW;
  localparam int CAW    = PAW + HISTORY_BITS;
  localparam int CLR_AW = (CAW > HAW) ? CAW : HAW;

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_HIST  = 2'd2;
  localparam logic [1:0] ST_CNT   = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [CLR_AW-1:0]       clr_r, clr_nxt;
  logic                    op_r;
  logic [HAW-1:0]          hidx_r;
  logic [PAW-1:0]          tsel_r;
  logic                    res_r;
  logic                    pred_r;
  logic [HISTORY_BITS-1:0] hist_r;
  logic                    out_valid_r, out_valid_nxt;
  logic                    out_pred_r;

  logic                    accept;
  logic                    out_free;
  logic                    finish;
  logic                    clearing;

  logic                    h_we;
  logic [HAW-1:0]          h_waddr;
  logic [HISTORY_BITS-1:0] h_wdata;
  logic [HAW-1:0]          h_raddr;
  logic [HISTORY_BITS-1:0] h_rdata;

  logic                    c_we;
  logic [CAW-1:0]          c_waddr;
  bp2l_pkg::ctr_t          c_wdata;
  logic [CAW-1:0]          c_raddr;
  bp2l_pkg::ctr_t          c_rdata;
  logic [HISTORY_BITS-1:0] hist_cur;

  assign clearing = (state_r == ST_CLEAR);
  assign accept   = in_valid && (state_r == ST_IDLE);
  assign in_stall = (state_r != ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  // An update never waits for the output register.
  assign finish   = (state_r == ST_CNT) && ((op_r == bp2l_pkg::OP_UPDATE) || out_free);

  always_comb begin
    state_nxt = state_r;
    clr_nxt   = clr_r;
    case (state_r)
      ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (&clr_r) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          state_nxt = ST_HIST;
        end
      end
      ST_HIST: state_nxt = ST_CNT;
      ST_CNT: begin
        if (finish) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (finish && (op_r == bp2l_pkg::OP_PREDICT)) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_operation;
      hidx_r <= in_pc[HAW-1:0];
      tsel_r <= in_pc[HAW+PAW-1:HAW];
      res_r  <= in_resolved_taken;
      pred_r <= in_predicted_taken;
    end
    if (state_r == ST_HIST) begin
      hist_r <= h_rdata;
    end
    if (finish && (op_r == bp2l_pkg::OP_PREDICT)) begin
      out_pred_r <= bp2l_pkg::ctr_taken(c_rdata);
    end
  end

  // History read is issued straight from the port on accept.
  assign h_raddr  = accept ? in_pc[HAW-1:0] : hidx_r;
  assign hist_cur = (state_r == ST_HIST) ? h_rdata : hist_r;
  assign c_raddr  = {tsel_r, hist_cur};

  // Clearing pass sweeps both tables together; each stops at its own depth.
  always_comb begin
    if (clearing) begin
      h_we    = ({1'b0, clr_r} < (CLR_AW + 1)'(bp2l_pkg::HIST_ENTRIES));
      h_waddr = clr_r[HAW-1:0];
      h_wdata = '0;
      c_we    = ({1'b0, clr_r} < (CLR_AW + 1)'(2 ** CAW));
      c_waddr = clr_r[CAW-1:0];
      c_wdata = bp2l_pkg::CTR_RESET;
    end else begin
      h_we    = finish && (op_r == bp2l_pkg::OP_UPDATE);
      h_waddr = hidx_r;
      h_wdata = HISTORY_BITS'({hist_r, res_r});
      c_we    = finish && (op_r == bp2l_pkg::OP_UPDATE);
      c_waddr = {tsel_r, hist_r};
      c_wdata = bp2l_pkg::next_counter(c_rdata, res_r == pred_r);
    end
  end

  bp2l_ram #(
    .AW (HAW),
    .DW (HISTORY_BITS)
  ) u_hist_ram (
    .clk   (clk),
    .we    (h_we),
    .waddr (h_waddr),
    .wdata (h_wdata),
    .raddr (h_raddr),
    .rdata (h_rdata)
  );

  bp2l_ram #(
    .AW (CAW),
    .DW (2)
  ) u_ctr_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (c_wdata),
    .raddr (c_raddr),
    .rdata (c_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_prediction = out_pred_r;

  `BP2L_ASSERT_SAME(a_no_result_while_clearing, clearing, !out_valid_r)
  `BP2L_ASSERT_NEXT(a_hist_then_cnt, state_r == ST_HIST, state_r == ST_CNT)
  `BP2L_ASSERT_NEXT(a_update_no_result,
                    (state_r == ST_CNT) && (op_r == bp2l_pkg::OP_UPDATE), !$rose(out_valid_r))
  `BP2L_ASSERT_SAME(a_writes_paired, !clearing && h_we, c_we && (state_r == ST_CNT))

endmodule

/* verif/tb_two_level_local_branch_predictor.sv */
module tb_two_level_local_branch_predictor;

  localparam int HB        = bp2l_pkg::HIST_BITS_DEF;
  localparam int HAW       = bp2l_pkg::HIST_AW;
  localparam int PAW       = bp2l_pkg::PAT_AW;
  localparam int N_ITEMS   = 650;
  localparam int TAIL_LEN  = 80;
  localparam int LIMIT     = 200000;
  localparam int N_HOT     = 12;

  typedef struct packed {
    logic        op;
    logic [31:0] pc;
    logic        res;
    logic        pred;
  } access_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_operation = bp2l_pkg::OP_PREDICT;
  logic [31:0] in_pc = '0;
  logic        in_resolved_taken = 1'b0;
  logic        in_predicted_taken = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_prediction;

  two_level_local_branch_predictor u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_pc              (in_pc),
    .in_resolved_taken  (in_resolved_taken),
    .in_predicted_taken (in_predicted_taken),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_prediction     (out_prediction)
  );

  // Shadow copy of the branch history registers and pattern counters
  logic [HB-1:0]  hist_regs [bp2l_pkg::HIST_ENTRIES];
  bp2l_pkg::ctr_t pattern_ctrs [bp2l_pkg::PAT_TABLES][2**HB];

  access_t access_q [$];
  logic    exp_dir_q [$];

  int      mismatches = 0;
  int      n_predicts = 0;
  int      n_updates = 0;
  int      n_results = 0;
  int      cycle_cnt = 0;
  int      gap_left = 0;
  int      stall_left = 0;
  logic    tail_phase = 1'b0;
  logic    idle_ok;

  // Monitor scratch
  logic [HAW-1:0]     m_hidx;
  logic [PAW-1:0]     m_tsel;
  logic [HB-1:0]      m_hist;
  bp2l_pkg::ctr_t     m_ctr;
  logic               m_exp;

  initial begin
    forever #4 clk = ~clk;
  end

  function automatic bp2l_pkg::ctr_t stepped_counter(input bp2l_pkg::ctr_t c,
                                                      input logic agree);
    bp2l_pkg::ctr_t n;
    if (agree) begin
      // strengthen within the current direction
      case (c)
        2'd1:    n = 2'd0;
        2'd2:    n = 2'd3;
        default: n = c;
      endcase
    end else begin
      // step toward the other direction
      case (c)
        2'd0:    n = 2'd1;
        2'd3:    n = 2'd2;
        2'd1:    n = 2'd2;
        default: n = 2'd1;
      endcase
    end
    return n;
  endfunction

  task automatic flag_mismatch(input string what);
    mismatches++;
    $display("MISMATCH @%0d: %s", cycle_cnt, what);
  endtask

  task automatic add_access(input logic op, input logic [31:0] pc, input logic res,
                            input logic pred);
    access_t a;
    a.op   = op;
    a.pc   = pc;
    a.res  = res;
    a.pred = pred;
    access_q = {access_q, a};
  endtask

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == LIMIT) begin
      $display("timeout after %0d cycles", cycle_cnt);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // New gaps and stalls start only while cycle_cnt[6:5] is nonzero, and none near the end
  assign idle_ok = !tail_phase && (cycle_cnt[6:5] != 2'd0);

  // Driver
  always @(posedge clk) begin
    access_t a;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left != 0) begin
        gap_left = gap_left - 1;
        in_valid <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        gap_left = int'($urandom_range(0, 6));
        in_valid <= 1'b0;
      end else if (access_q.size() != 0) begin
        a = access_q.pop_front();
        in_valid           <= 1'b1;
        in_operation       <= a.op;
        in_pc              <= a.pc;
        in_resolved_taken  <= a.res;
        in_predicted_taken <= a.pred;
      end else begin
        in_valid <= 1'b0;
      end
    end
    tail_phase <= (access_q.size() < TAIL_LEN);
  end

  // Monitor: check results, then fold accepted items into the shadow tables
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (exp_dir_q.size() == 0) begin
          flag_mismatch($sformatf("prediction %0b with none expected", out_prediction));
        end else begin
          m_exp = exp_dir_q.pop_front();
          if (out_prediction !== m_exp)
            flag_mismatch($sformatf("prediction got %0b want %0b", out_prediction, m_exp));
        end
      end

      if (in_valid && !in_stall) begin
        m_hidx = in_pc[HAW-1:0];
        m_tsel = in_pc[HAW+PAW-1:HAW];
        m_hist = hist_regs[m_hidx];
        m_ctr  = pattern_ctrs[m_tsel][m_hist];
        if (in_operation == bp2l_pkg::OP_PREDICT) begin
          exp_dir_q = {exp_dir_q, m_ctr[1]};
          n_predicts++;
        end else begin
          pattern_ctrs[m_tsel][m_hist] =
            stepped_counter(m_ctr, in_resolved_taken == in_predicted_taken);
          hist_regs[m_hidx] = {m_hist[HB-2:0], in_resolved_taken};
          n_updates++;
        end
      end

      if (stall_left != 0) begin
        stall_left = stall_left - 1;
        out_stall <= 1'b1;
      end else if (idle_ok && $urandom_range(0, 5) == 0) begin
        stall_left = int'($urandom_range(0, 6));
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    logic [11:0] hot_lo [N_HOT];
    int          period [N_HOT];
    int          iter [N_HOT];
    int          n_added;
    int          k;
    int          mode;
    logic        res;
    logic        pred;

    for (int i = 0; i < bp2l_pkg::HIST_ENTRIES; i++) hist_regs[i] = '0;
    for (int t = 0; t < bp2l_pkg::PAT_TABLES; t++)
      for (int p = 0; p < 2**HB; p++) pattern_ctrs[t][p] = bp2l_pkg::CTR_RESET;

    // Directed: reset state, aliasing through ignored upper pc bits,
    // every counter transition, and a saturated history
    add_access(bp2l_pkg::OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
    add_access(bp2l_pkg::OP_PREDICT, 32'hFFFF_FFFF, 1'b0, 1'b1);
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1);   // 1 -> 2
    add_access(bp2l_pkg::OP_PREDICT, 32'hFFFF_F000, 1'b1, 1'b0);   // same entries as pc 0
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0);   // 2 -> 3
    add_access(bp2l_pkg::OP_PREDICT, 32'h0000_0000, 1'b0, 1'b0);
    add_access(bp2l_pkg::OP_UPDATE,  32'hABCD_E000, 1'b0, 1'b1);   // 3 -> 2 through alias
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1);   // 2 -> 1
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0);   // 1 -> 0
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b0);   // 0 holds
    add_access(bp2l_pkg::OP_PREDICT, 32'h0000_0000, 1'b1, 1'b1);
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0000, 1'b0, 1'b1);   // 0 -> 1
    for (int i = 0; i < 6; i++)
      add_access(bp2l_pkg::OP_UPDATE, 32'hFFFF_FFFF, 1'b1, 1'b1);  // fill history with ones
    add_access(bp2l_pkg::OP_PREDICT, 32'h0000_0FFF, 1'b1, 1'b1);
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0FFF, 1'b1, 1'b0);   // 1 -> 2
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0FFF, 1'b1, 1'b1);   // 2 -> 3
    add_access(bp2l_pkg::OP_UPDATE,  32'h0000_0FFF, 1'b1, 1'b1);   // 3 holds
    add_access(bp2l_pkg::OP_PREDICT, 32'h5555_5FFF, 1'b0, 1'b0);
    add_access(bp2l_pkg::OP_PREDICT, 32'h0000_01FF, 1'b0, 1'b0);   // same history, table 0

    for (int i = 0; i < N_HOT; i++) begin
      hot_lo[i] = 12'($urandom_range(0, 4095));
      period[i] = int'($urandom_range(2, 9));
      iter[i]   = 0;
    end
    // same history register, different pattern tables
    hot_lo[1] = hot_lo[0] ^ 12'h200;
    hot_lo[2] = hot_lo[0] ^ 12'hE00;

    n_added = 0;
    while (n_added < N_ITEMS) begin
      mode = int'($urandom_range(0, 9));
      if (mode <= 6) begin
        // loop-like branch: predict, then resolve mostly as predicted
        k = int'($urandom_range(0, N_HOT - 1));
        res = ((iter[k] % period[k]) != period[k] - 1);
        iter[k]++;
        pred = ($urandom_range(0, 3) != 0) ? res : ~res;
        add_access(bp2l_pkg::OP_PREDICT, {20'($urandom_range(0, 1048575)), hot_lo[k]},
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        add_access(bp2l_pkg::OP_UPDATE, {20'($urandom_range(0, 1048575)), hot_lo[k]},
                   res, pred);
        n_added += 2;
      end else if (mode <= 8) begin
        add_access(bp2l_pkg::OP_UPDATE, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        n_added++;
      end else begin
        add_access(bp2l_pkg::OP_PREDICT, $urandom, 1'($urandom_range(0, 1)),
                   1'($urandom_range(0, 1)));
        n_added++;
      end
    end

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    while (access_q.size() != 0 || in_valid) @(negedge clk);
    while (exp_dir_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);

    $display("covered %0d predicts and %0d updates, %0d predictions returned",
             n_predicts, n_updates, n_results);
    $display("%0d mismatches in %0d cycles", mismatches, cycle_cnt);
    if (mismatches == 0 && exp_dir_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/bp2l_pkg.sv
sv/bp2l_ram.sv
sv/two_level_local_branch_predictor.sv
verif/tb_two_level_local_branch_predictor.sv
